[hw/rtl/hdte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP date to epoch seconds: shared types, constants and helpers
// Widths, parse phases, status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hdte_pkg;

  localparam int MAX_DIGITS = 4;
  localparam int MIN_LENGTH = 20;

  localparam int ACC_W  = $clog2(10 ** MAX_DIGITS);
  localparam int TL_W   = $clog2(((MAX_DIGITS > 3) ? MAX_DIGITS : 3) + 1);
  localparam int LEN_W  = $clog2(MIN_LENGTH + 1);
  localparam int SEC_W  = 40;
  localparam int STAT_W = 3;
  localparam int YOE_W  = 9;
  localparam int ERA_W  = (ACC_W > 9) ? ACC_W - 6 : 3;
  localparam int Q_W    = ERA_W - 1;
  localparam int REM_W  = (ACC_W >= 9) ? ACC_W + 1 : 10;
  localparam int DOE_W  = ((ACC_W > 18) ? ACC_W : 18) + 2;
  localparam int DAYS_W = (ACC_W + 13 > DOE_W + 1) ? ACC_W + 13 : DOE_W + 1;
  localparam int HMS_W  = ACC_W + 12;

  // floor(y / 400) by reciprocal multiply, then one correction step
  localparam int RCP_SHIFT = ACC_W + 9;
  localparam int RCP_W     = ACC_W + 1;
  localparam int PROD_W    = ACC_W + RCP_W;
  localparam logic [RCP_W-1:0] ERA_RECIP = RCP_W'((64'd1 << RCP_SHIFT) / 64'd400);

  localparam logic [8:0]              YEARS_PER_ERA  = 9'd400;
  localparam logic [8:0]              DAYS_PER_YEAR  = 9'd365;
  localparam logic signed [18:0]      DAYS_PER_ERA   = 19'sd146097;
  localparam logic signed [DAYS_W-1:0] EPOCH_DAYS    = DAYS_W'(719468);
  localparam logic signed [17:0]      SECS_PER_DAY   = 18'sd86400;
  localparam logic [11:0]             SECS_PER_HOUR  = 12'd3600;
  localparam logic [5:0]              SECS_PER_MIN   = 6'd60;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [3:0] {
    PH_WD_PRE, PH_WD, PH_DAY_PRE, PH_DAY, PH_MON_PRE, PH_MON,
    PH_YEAR_PRE, PH_YEAR, PH_HOUR_PRE, PH_HOUR, PH_MIN_PRE, PH_MIN,
    PH_SEC_PRE, PH_SEC, PH_DONE
  } phase_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK, ST_SHORT, ST_MISMATCH, ST_MONTH, ST_LONG
  } status_t;

  typedef enum logic [2:0] {
    S_RUN, S_MONTH, S_ERA, S_CORR, S_DOE, S_DAYS, S_MUL, S_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic parse;
    logic ld_month;
    logic ld_era;
    logic ld_corr;
    logic ld_doe;
    logic ld_days;
    logic ld_mul;
    logic ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic out_pending;
  } dp_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // 1..12 for a known month token, 0 otherwise
  function automatic logic [3:0] month_index(input logic [23:0] t);
    logic [3:0] m;
    unique case (t)
      "Jan":   m = 4'd1;
      "Feb":   m = 4'd2;
      "Mar":   m = 4'd3;
      "Apr":   m = 4'd4;
      "May":   m = 4'd5;
      "Jun":   m = 4'd6;
      "Jul":   m = 4'd7;
      "Aug":   m = 4'd8;
      "Sep":   m = 4'd9;
      "Oct":   m = 4'd10;
      "Nov":   m = 4'd11;
      "Dec":   m = 4'd12;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  // Day of a March-based year on which the month starts
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] b;
    unique case (m)
      4'd1:    b = 9'd306;
      4'd2:    b = 9'd337;
      4'd3:    b = 9'd0;
      4'd4:    b = 9'd31;
      4'd5:    b = 9'd61;
      4'd6:    b = 9'd92;
      4'd7:    b = 9'd122;
      4'd8:    b = 9'd153;
      4'd9:    b = 9'd184;
      4'd10:   b = 9'd214;
      4'd11:   b = 9'd245;
      4'd12:   b = 9'd275;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] div100(input logic [YOE_W-1:0] v);
    logic [1:0] q;
    priority if (v >= YOE_W'(300)) q = 2'd3;
    else if (v >= YOE_W'(200))     q = 2'd2;
    else if (v >= YOE_W'(100))     q = 2'd1;
    else                           q = 2'd0;
    return q;
  endfunction

endpackage

[hw/rtl/http_date_to_epoch_seconds_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP date to epoch seconds, top level
// Usage:
//   Feed the Date header text one byte per request on the input channel,
//   in_last_char set on the final byte. Bytes are taken one per cycle
//   while the block is parsing. A NUL byte ends the text; later bytes only
//   count toward the length check.
//   The final byte starts a seven-step conversion sequence (month lookup,
//   era split by reciprocal multiply, day count, day-to-seconds multiply);
//   in_stall stays high through it, and the result request appears on
//   the output channel when the last step loads the output register.
//   Throughput is one byte per cycle, stalled during each conversion.
//   Non-final bytes give no result. out_status: 0 ok, 1 too short,
//   2 pattern mismatch, 3 unknown month, 4 number too long;
//   out_epoch_seconds is zero unless the status is ok.
//   The output register holds a result while out_stall is high and the
//   next header is parsed meanwhile; its conversion waits in the last step
//   until the register is free.
//   Synchronous reset clears the parser and drops any pending result.
// ----------------------------------------------------------------------------
module http_date_to_epoch_seconds_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_character,
  input  logic                               in_last_char,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hdte_pkg::STAT_W-1:0]        out_status,
  output logic signed [hdte_pkg::SEC_W-1:0]  out_epoch_seconds
);
  import hdte_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hdte_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_char (in_last_char),
    .stat         (stat),
    .cmd          (cmd),
    .in_stall     (in_stall)
  );

  hdte_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_character      (in_character),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_epoch_seconds (out_epoch_seconds)
  );

  // a final byte always starts the conversion, which blocks new input
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_char) |=> in_stall)
    else $error("input taken right after a final byte");

  // a failed header never reports a time
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_epoch_seconds == '0))
    else $error("nonzero seconds with a failure status");

  // results only come out of the conversion sequence
  a_rise_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a conversion");

  // the output register is loaded only when it is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!stat.out_pending || !out_stall))
    else $error("pending result overwritten");

endmodule

[hw/rtl/hdte_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP date controller
// Steps the datapath: character parsing, the conversion sequence after
// the last character, and the hand-off into the output register.
// ----------------------------------------------------------------------------
module hdte_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_char,
  input  hdte_pkg::dp_stat_t stat,
  output hdte_pkg::dp_cmd_t  cmd,
  output logic               in_stall
);
  import hdte_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RUN: begin
        if (in_valid && in_last_char) state_nxt = S_MONTH;
      end
      S_MONTH: state_nxt = S_ERA;
      S_ERA:   state_nxt = S_CORR;
      S_CORR:  state_nxt = S_DOE;
      S_DOE:   state_nxt = S_DAYS;
      S_DAYS:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_LOAD;
      S_LOAD: begin
        // hold until the output register can take the result
        if (stat.out_free) state_nxt = S_RUN;
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_RUN: begin
        in_stall  = 1'b0;
        cmd.parse = in_valid;
      end
      S_MONTH: cmd.ld_month = 1'b1;
      S_ERA:   cmd.ld_era   = 1'b1;
      S_CORR:  cmd.ld_corr  = 1'b1;
      S_DOE:   cmd.ld_doe   = 1'b1;
      S_DAYS:  cmd.ld_days  = 1'b1;
      S_MUL:   cmd.ld_mul   = 1'b1;
      S_LOAD:  cmd.ld_out   = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/hdte_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP date datapath
// Pattern parser over the header characters, the days-from-civil
// conversion registers and the output register.
// ----------------------------------------------------------------------------
module hdte_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hdte_pkg::dp_cmd_t                   cmd,
  output hdte_pkg::dp_stat_t                  stat,
  input  logic [7:0]                          in_character,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hdte_pkg::STAT_W-1:0]         out_status,
  output logic signed [hdte_pkg::SEC_W-1:0]   out_epoch_seconds
);
  import hdte_pkg::*;

  // parser state
  phase_t           phase_r, phase_nxt;
  logic [TL_W-1:0]  tl_r, tl_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  status_t          fail_r, fail_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [23:0]      mon_r, mon_nxt;
  logic [ACC_W-1:0] day_r, day_nxt;
  logic [ACC_W-1:0] year_r, year_nxt;
  logic [ACC_W-1:0] hour_r, hour_nxt;
  logic [ACC_W-1:0] min_r, min_nxt;

  // conversion registers
  status_t                  stat_r, stat_nxt;
  logic [3:0]               month_r, month_nxt;
  logic signed [DOE_W-1:0]  doy_r, doy_nxt;
  logic                     yneg_r, yneg_nxt;
  logic [ACC_W-1:0]         y_r, y_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic signed [ERA_W-1:0]  era_r, era_nxt;
  logic [YOE_W-1:0]         yoe_r, yoe_nxt;
  logic signed [DOE_W-1:0]  doe_r, doe_nxt;
  logic signed [DAYS_W-1:0] days_r, days_nxt;
  logic [HMS_W-1:0]         hms_r, hms_nxt;
  logic [SEC_W-1:0]         mul_r, mul_nxt;

  // output register
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [SEC_W-1:0]         out_epoch_r, out_epoch_nxt;

  logic [Q_W-1:0]                 q_est;
  logic [REM_W-1:0]               rem;
  logic signed [ERA_W+18:0]       era_days;
  logic signed [DAYS_W+17:0]      day_secs;

  // ---------------------------------------------------------------- parser
  always_comb begin
    logic             sp;
    logic             dg;
    logic [ACC_W-1:0] dval;
    phase_t           eff;

    sp   = is_space(in_character);
    dg   = is_digit(in_character);
    dval = ACC_W'(in_character - CH_ZERO);
    eff  = phase_r;

    phase_nxt = phase_r;
    tl_nxt    = tl_r;
    fail_nxt  = fail_r;
    acc_nxt   = acc_r;
    mon_nxt   = mon_r;
    day_nxt   = day_r;
    year_nxt  = year_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    len_nxt   = (len_r < LEN_W'(MIN_LENGTH)) ? len_r + LEN_W'(1) : len_r;

    if (in_character == CH_NUL) begin
      // end of text: only a seconds field in progress completes the pattern
      if (fail_r == ST_OK) begin
        if (phase_r == PH_SEC) begin
          phase_nxt = PH_DONE;
        end else if (phase_r != PH_DONE) begin
          fail_nxt = ST_MISMATCH;
        end
      end
    end else if (fail_r == ST_OK) begin
      // a day, month or year field that ends on this character hands it to the next phase
      unique case (phase_r)
        PH_DAY: begin
          if (!dg) begin
            day_nxt = acc_r;
            eff     = PH_MON_PRE;
          end
        end
        PH_MON: begin
          if (sp || tl_r >= TL_W'(3)) eff = PH_YEAR_PRE;
        end
        PH_YEAR: begin
          if (!dg) begin
            year_nxt = acc_r;
            eff      = PH_HOUR_PRE;
          end
        end
        default: eff = phase_r;
      endcase
      phase_nxt = eff;

      unique case (eff)
        PH_WD_PRE: begin
          if (!sp) begin
            tl_nxt    = TL_W'(1);
            phase_nxt = PH_WD;
          end
        end
        PH_WD: begin
          if (!sp && tl_r < TL_W'(3)) begin
            tl_nxt = tl_r + TL_W'(1);
          end else if (in_character == CH_COMMA) begin
            phase_nxt = PH_DAY_PRE;
          end else begin
            fail_nxt = ST_MISMATCH;
          end
        end
        PH_DAY_PRE, PH_YEAR_PRE, PH_HOUR_PRE, PH_MIN_PRE, PH_SEC_PRE: begin
          if (!sp) begin
            if (!dg) begin
              fail_nxt = ST_MISMATCH;
            end else begin
              acc_nxt   = dval;
              tl_nxt    = TL_W'(1);
              phase_nxt = phase_t'(eff + 4'd1);
            end
          end
        end
        PH_DAY, PH_YEAR, PH_HOUR, PH_MIN, PH_SEC: begin
          if (dg) begin
            if (tl_r >= TL_W'(MAX_DIGITS)) begin
              fail_nxt = ST_LONG;
            end else begin
              tl_nxt  = tl_r + TL_W'(1);
              acc_nxt = ACC_W'((acc_r << 3) + (acc_r << 1) + dval);
            end
          end else if (eff == PH_HOUR) begin
            hour_nxt = acc_r;
            if (in_character == CH_COLON) phase_nxt = PH_MIN_PRE;
            else fail_nxt = ST_MISMATCH;
          end else if (eff == PH_MIN) begin
            min_nxt = acc_r;
            if (in_character == CH_COLON) phase_nxt = PH_SEC_PRE;
            else fail_nxt = ST_MISMATCH;
          end else if (eff == PH_SEC) begin
            phase_nxt = PH_DONE;
          end
        end
        PH_MON_PRE: begin
          if (!sp) begin
            mon_nxt   = {in_character, 16'h0000};
            tl_nxt    = TL_W'(1);
            phase_nxt = PH_MON;
          end
        end
        PH_MON: begin
          if (tl_r == TL_W'(1)) mon_nxt[15:8] = in_character;
          else mon_nxt[7:0] = in_character;
          tl_nxt = tl_r + TL_W'(1);
        end
        default: phase_nxt = eff;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.ld_out) begin
      phase_r <= PH_WD_PRE;
      tl_r    <= '0;
      len_r   <= '0;
      fail_r  <= ST_OK;
    end else if (cmd.parse) begin
      phase_r <= phase_nxt;
      tl_r    <= tl_nxt;
      len_r   <= len_nxt;
      fail_r  <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.parse) begin
      acc_r  <= acc_nxt;
      mon_r  <= mon_nxt;
      day_r  <= day_nxt;
      year_r <= year_nxt;
      hour_r <= hour_nxt;
      min_r  <= min_nxt;
    end
  end

  // ------------------------------------------------------------ conversion
  always_comb begin
    logic [3:0] m;

    m         = month_index(mon_r);
    month_nxt = m;
    priority if (len_r < LEN_W'(MIN_LENGTH))            stat_nxt = ST_SHORT;
    else if (fail_r != ST_OK)                           stat_nxt = fail_r;
    else if (phase_r != PH_SEC && phase_r != PH_DONE)   stat_nxt = ST_MISMATCH;
    else if (m == 4'd0)                                 stat_nxt = ST_MONTH;
    else                                                stat_nxt = ST_OK;
    doy_nxt = DOE_W'(month_base(m)) + DOE_W'(day_r) - DOE_W'(1);
  end

  always_comb begin
    logic mlow;
    mlow     = (month_r <= 4'd2);
    yneg_nxt = mlow && (year_r == '0);
    y_nxt    = year_r - ACC_W'(mlow);
    prod_nxt = PROD_W'(y_nxt) * PROD_W'(ERA_RECIP);
  end

  always_comb begin
    logic [Q_W-1:0] q_fix;
    q_est = Q_W'(prod_r >> RCP_SHIFT);
    rem   = REM_W'(y_r) - REM_W'(q_est) * REM_W'(YEARS_PER_ERA);
    if (rem >= REM_W'(YEARS_PER_ERA)) begin
      q_fix   = q_est + Q_W'(1);
      yoe_nxt = YOE_W'(rem - REM_W'(YEARS_PER_ERA));
    end else begin
      q_fix   = q_est;
      yoe_nxt = YOE_W'(rem);
    end
    // year -1 (January or February of year 0) sits in era -1
    if (yneg_r) begin
      era_nxt = '1;
      yoe_nxt = YOE_W'(399);
    end else begin
      era_nxt = ERA_W'(q_fix);
    end
  end

  always_comb begin
    doe_nxt = DOE_W'(yoe_r) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(yoe_r >> 2)
              - DOE_W'(div100(yoe_r)) + doy_r;
  end

  always_comb begin
    era_days = era_r * DAYS_PER_ERA;
    days_nxt = DAYS_W'(era_days) + DAYS_W'(doe_r) - EPOCH_DAYS;
    hms_nxt  = HMS_W'(hour_r) * HMS_W'(SECS_PER_HOUR)
               + HMS_W'(min_r) * HMS_W'(SECS_PER_MIN) + HMS_W'(acc_r);
  end

  always_comb begin
    day_secs = days_r * SECS_PER_DAY;
    mul_nxt  = SEC_W'(day_secs);
  end

  always_comb begin
    if (stat_r == ST_OK) out_epoch_nxt = mul_r + SEC_W'(hms_r);
    else out_epoch_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_month) begin
      month_r <= month_nxt;
      stat_r  <= stat_nxt;
      doy_r   <= doy_nxt;
    end
    if (cmd.ld_era) begin
      yneg_r <= yneg_nxt;
      y_r    <= y_nxt;
      prod_r <= prod_nxt;
    end
    if (cmd.ld_corr) begin
      era_r <= era_nxt;
      yoe_r <= yoe_nxt;
    end
    if (cmd.ld_doe) begin
      doe_r <= doe_nxt;
    end
    if (cmd.ld_days) begin
      days_r <= days_nxt;
      hms_r  <= hms_nxt;
    end
    if (cmd.ld_mul) begin
      mul_r <= mul_nxt;
    end
  end

  // -------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_status_r <= stat_r;
      out_epoch_r  <= out_epoch_nxt;
    end
  end

  assign stat.out_free    = !out_valid_r || !out_stall;
  assign stat.out_pending = out_valid_r;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_epoch_seconds = $signed(out_epoch_r);

endmodule
